// ===== src/ptds_pkg.sv =====
// Shared types and constants of the point-to-triangle squared distance unit.
package ptds_pkg;

   // Result field widths and the packed response width.
   localparam int REGION_W    = 3;
   localparam int DIST_W      = 50;
   localparam int RSP_TDATA_W = ((REGION_W + DIST_W + 1 + 7) / 8) * 8;

   // Feature of the triangle that lies closest to the query point.
   typedef enum logic [REGION_W-1:0] {
      REGION_A   = 3'd0,
      REGION_B   = 3'd1,
      REGION_C   = 3'd2,
      REGION_AB  = 3'd3,
      REGION_BC  = 3'd4,
      REGION_CA  = 3'd5,
      REGION_INT = 3'd6
   } region_type;

   // Slots of the dot product bank.
   localparam int DOT_D1 = 0;
   localparam int DOT_D2 = 1;
   localparam int DOT_D3 = 2;
   localparam int DOT_D4 = 3;
   localparam int DOT_D5 = 4;
   localparam int DOT_D6 = 5;
   localparam int DOT_AP = 6;
   localparam int DOT_BP = 7;
   localparam int DOT_CP = 8;
   localparam int DOT_AB = 9;
   localparam int DOT_AC = 10;
   localparam int DOT_CB = 11;
   localparam int DOT_N  = 12;

endpackage

// ===== src/point_triangle_distance_squared_unit.sv =====
// Pipelined squared distance from a point to a triangle, by Voronoi region.
// Throughput: one request per cycle while the output is not stalled; the 50 restoring
// division stages, one quotient bit each, set the depth, and every stage holds its
// request on a stall. Reset (synchronous, active high) clears all stage valid bits;
// data registers keep whatever they hold.
module point_triangle_distance_squared_unit #(
   parameter int COORD_BITS = 16,
   parameter int FRAC_BITS  = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // p_x, p_y, p_z, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z from bit 0 up
   input  logic [((12*COORD_BITS+7)/8)*8-1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // region, dist_sq, degenerate from bit 0 up
   output logic [ptds_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   localparam int DIST_W = ptds_pkg::DIST_W;
   localparam int NDOT   = ptds_pkg::DOT_N;
   localparam int DFW    = COORD_BITS + 1;
   localparam int PW     = 2 * DFW;
   localparam int DW     = PW + 2;
   localparam int NW     = PW + 1;
   localparam int DTW    = 2 * DW;
   localparam int NSQW   = 2 * NW;
   localparam int NNW    = NSQW + 2;
   localparam int APNW   = DFW + NW;
   localparam int SW     = APNW + 2;
   localparam int SH     = (SW + 1) / 2;
   localparam int SHI    = SW - SH;
   localparam int NMW    = 2 * SW;
   localparam int NSW    = NMW + FRAC_BITS;
   localparam int HW     = NSW - DIST_W;
   localparam int DNW    = NNW;
   localparam int RW     = DNW + 1;
   localparam int CW     = (HW > DNW) ? HW : DNW;
   localparam int SQW    = DW + FRAC_BITS + DIST_W;
   localparam int DIV0   = 8;
   localparam int NSTG   = DIV0 + 1 + DIST_W;

   // Difference vector slots.
   localparam int V_AB = 0;
   localparam int V_AC = 1;
   localparam int V_AP = 2;
   localparam int V_BP = 3;
   localparam int V_CP = 4;
   localparam int V_CB = 5;

   // Operand pairs of the dot product bank.
   localparam int DOT_L [NDOT] = '{V_AB, V_AC, V_AB, V_AC, V_AB, V_AC,
                                   V_AP, V_BP, V_CP, V_AB, V_AC, V_CB};
   localparam int DOT_R [NDOT] = '{V_AP, V_AP, V_BP, V_BP, V_CP, V_CP,
                                   V_AP, V_BP, V_CP, V_AB, V_AC, V_CB};

   // Saturating conversion of an integer square to fixed point.
   function automatic logic [DIST_W-1:0] sq_fix(input logic [DW-1:0] x);
      logic [SQW-1:0] t;
      t = SQW'(x) << FRAC_BITS;
      if ((t >> DIST_W) != '0) begin
         return '1;
      end
      return t[DIST_W-1:0];
   endfunction

   // Magnitude of a signed dot product.
   function automatic logic [DW-1:0] abs_dot(input logic signed [DW-1:0] x);
      return x[DW-1] ? DW'(-x) : DW'(x);
   endfunction

   // Stage handshake: a stage takes new contents when it is empty or its successor moves.
   logic [NSTG-1:0] vld_ff;
   logic [NSTG-1:0] vld_in;
   logic [NSTG-1:0] rdy;

   assign rdy[NSTG-1] = !vld_ff[NSTG-1] || rsp_tready;
   for (genvar k = 0; k < NSTG - 1; k++) begin : g_rdy
      assign rdy[k] = !vld_ff[k] || rdy[k+1];
   end

   assign req_tready = rdy[0];
   assign rsp_tvalid = vld_ff[NSTG-1];
   assign vld_in     = {vld_ff[NSTG-2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 0; k < NSTG; k++) begin
            if (rdy[k]) begin
               vld_ff[k] <= vld_in[k];
            end
         end
      end
   end

   // Stage 1: edge and offset vectors.
   logic signed [COORD_BITS-1:0] pt [4][3];
   logic signed [DFW-1:0] diff_in [6][3];
   logic signed [DFW-1:0] diff_ff [6][3];

   always_comb begin
      for (int v = 0; v < 4; v++) begin
         for (int i = 0; i < 3; i++) begin
            pt[v][i] = req_tdata[(3*v+i)*COORD_BITS +: COORD_BITS];
         end
      end
      for (int i = 0; i < 3; i++) begin
         diff_in[V_AB][i] = DFW'(pt[2][i]) - DFW'(pt[1][i]);
         diff_in[V_AC][i] = DFW'(pt[3][i]) - DFW'(pt[1][i]);
         diff_in[V_AP][i] = DFW'(pt[0][i]) - DFW'(pt[1][i]);
         diff_in[V_BP][i] = DFW'(pt[0][i]) - DFW'(pt[2][i]);
         diff_in[V_CP][i] = DFW'(pt[0][i]) - DFW'(pt[3][i]);
         diff_in[V_CB][i] = DFW'(pt[3][i]) - DFW'(pt[2][i]);
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         diff_ff <= diff_in;
      end
   end

   // Stage 2: component products of the dot products and of the normal.
   logic signed [PW-1:0]  prod_in [NDOT][3];
   logic signed [PW-1:0]  prod_ff [NDOT][3];
   logic signed [PW-1:0]  xp_in [6];
   logic signed [PW-1:0]  xp_ff [6];
   logic signed [DFW-1:0] ap2_ff [3];

   always_comb begin
      for (int k = 0; k < NDOT; k++) begin
         for (int i = 0; i < 3; i++) begin
            prod_in[k][i] = PW'(diff_ff[DOT_L[k]][i]) * PW'(diff_ff[DOT_R[k]][i]);
         end
      end
      xp_in[0] = PW'(diff_ff[V_AB][1]) * PW'(diff_ff[V_AC][2]);
      xp_in[1] = PW'(diff_ff[V_AB][2]) * PW'(diff_ff[V_AC][1]);
      xp_in[2] = PW'(diff_ff[V_AB][2]) * PW'(diff_ff[V_AC][0]);
      xp_in[3] = PW'(diff_ff[V_AB][0]) * PW'(diff_ff[V_AC][2]);
      xp_in[4] = PW'(diff_ff[V_AB][0]) * PW'(diff_ff[V_AC][1]);
      xp_in[5] = PW'(diff_ff[V_AB][1]) * PW'(diff_ff[V_AC][0]);
   end

   always_ff @(posedge clock) begin
      if (rdy[1]) begin
         prod_ff <= prod_in;
         xp_ff   <= xp_in;
         ap2_ff  <= diff_ff[V_AP];
      end
   end

   // Stage 3: dot product sums and normal components.
   logic signed [DW-1:0]  dot_in [NDOT];
   logic signed [DW-1:0]  dot3_ff [NDOT];
   logic signed [NW-1:0]  n_in [3];
   logic signed [NW-1:0]  n_ff [3];
   logic signed [DFW-1:0] ap3_ff [3];

   always_comb begin
      for (int k = 0; k < NDOT; k++) begin
         dot_in[k] = DW'(prod_ff[k][0]) + DW'(prod_ff[k][1]) + DW'(prod_ff[k][2]);
      end
      for (int i = 0; i < 3; i++) begin
         n_in[i] = NW'(xp_ff[2*i]) - NW'(xp_ff[2*i+1]);
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[2]) begin
         dot3_ff <= dot_in;
         n_ff    <= n_in;
         ap3_ff  <= ap2_ff;
      end
   end

   // Stage 4: determinant products, normal squares and the plane offset terms.
   logic signed [DTW-1:0]  det_in [6];
   logic signed [DTW-1:0]  det_ff [6];
   logic signed [NSQW-1:0] nsq_in [3];
   logic signed [NSQW-1:0] nsq_ff [3];
   logic signed [APNW-1:0] apn_in [3];
   logic signed [APNW-1:0] apn_ff [3];
   logic signed [DW-1:0]   dot4_ff [NDOT];

   always_comb begin
      det_in[0] = DTW'(dot3_ff[ptds_pkg::DOT_D1]) * DTW'(dot3_ff[ptds_pkg::DOT_D4]);
      det_in[1] = DTW'(dot3_ff[ptds_pkg::DOT_D3]) * DTW'(dot3_ff[ptds_pkg::DOT_D2]);
      det_in[2] = DTW'(dot3_ff[ptds_pkg::DOT_D5]) * DTW'(dot3_ff[ptds_pkg::DOT_D2]);
      det_in[3] = DTW'(dot3_ff[ptds_pkg::DOT_D1]) * DTW'(dot3_ff[ptds_pkg::DOT_D6]);
      det_in[4] = DTW'(dot3_ff[ptds_pkg::DOT_D3]) * DTW'(dot3_ff[ptds_pkg::DOT_D6]);
      det_in[5] = DTW'(dot3_ff[ptds_pkg::DOT_D5]) * DTW'(dot3_ff[ptds_pkg::DOT_D4]);
      for (int i = 0; i < 3; i++) begin
         nsq_in[i] = NSQW'(n_ff[i]) * NSQW'(n_ff[i]);
         apn_in[i] = APNW'(ap3_ff[i]) * APNW'(n_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[3]) begin
         det_ff  <= det_in;
         nsq_ff  <= nsq_in;
         apn_ff  <= apn_in;
         dot4_ff <= dot3_ff;
      end
   end

   // Stage 5: region classification in the fixed test order, |n|^2 and AP.n.
   ptds_pkg::region_type region_in;
   ptds_pkg::region_type region5_ff;
   logic signed [NNW-1:0] nn_in;
   logic signed [NNW-1:0] nn_ff;
   logic signed [SW-1:0]  s_in;
   logic signed [SW-1:0]  s_ff;
   logic signed [DW-1:0]  dot5_ff [NDOT];
   logic signed [DW-1:0]  d1, d2, d3, d4, d5, d6;

   always_comb begin
      d1 = dot4_ff[ptds_pkg::DOT_D1];
      d2 = dot4_ff[ptds_pkg::DOT_D2];
      d3 = dot4_ff[ptds_pkg::DOT_D3];
      d4 = dot4_ff[ptds_pkg::DOT_D4];
      d5 = dot4_ff[ptds_pkg::DOT_D5];
      d6 = dot4_ff[ptds_pkg::DOT_D6];
      priority if (d1 <= 0 && d2 <= 0) begin
         region_in = ptds_pkg::REGION_A;
      end else if (d3 >= 0 && d4 <= d3) begin
         region_in = ptds_pkg::REGION_B;
      end else if (det_ff[0] <= det_ff[1] && d1 >= 0 && d3 <= 0) begin
         region_in = ptds_pkg::REGION_AB;
      end else if (d6 >= 0 && d5 <= d6) begin
         region_in = ptds_pkg::REGION_C;
      end else if (det_ff[2] <= det_ff[3] && d2 >= 0 && d6 <= 0) begin
         region_in = ptds_pkg::REGION_CA;
      end else if (det_ff[4] <= det_ff[5] && d4 >= d3 && d5 >= d6) begin
         region_in = ptds_pkg::REGION_BC;
      end else begin
         region_in = ptds_pkg::REGION_INT;
      end
      nn_in = NNW'(nsq_ff[0]) + NNW'(nsq_ff[1]) + NNW'(nsq_ff[2]);
      s_in  = SW'(apn_ff[0]) + SW'(apn_ff[1]) + SW'(apn_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (rdy[4]) begin
         region5_ff <= region_in;
         nn_ff      <= nn_in;
         s_ff       <= s_in;
         dot5_ff    <= dot4_ff;
      end
   end

   // Stage 6: pick the divisor and the numerator operands of the chosen feature.
   logic [DW-1:0]     vv_in, uu_in, dm_in;
   logic [DW-1:0]     vv_ff, uu_ff, dm_ff;
   logic [SW-1:0]     s_abs;
   logic [SHI-1:0]    sh_in, sh_ff;
   logic [SH-1:0]     sl_in, sl_ff;
   logic [DNW-1:0]    den_in, den6_ff;
   logic              vert, deg_in, byp_in, intr_in;
   logic              deg6_ff, byp6_ff, intr6_ff;
   logic [DIST_W-1:0] vsq;
   logic [DIST_W-1:0] bval_in, bval6_ff;
   logic [DW-1:0]     dbc;
   ptds_pkg::region_type region6_ff;

   always_comb begin
      s_abs = s_ff[SW-1] ? SW'(-s_ff) : SW'(s_ff);
      sh_in = s_abs[SW-1:SH];
      sl_in = s_abs[SH-1:0];
      dbc   = DW'(dot5_ff[ptds_pkg::DOT_D4] - dot5_ff[ptds_pkg::DOT_D3]);
      vv_in = dot5_ff[ptds_pkg::DOT_AP];
      uu_in = dot5_ff[ptds_pkg::DOT_AB];
      dm_in = abs_dot(dot5_ff[ptds_pkg::DOT_D1]);
      vert  = 1'b0;
      vsq   = sq_fix(dot5_ff[ptds_pkg::DOT_AP]);
      unique case (region5_ff)
         ptds_pkg::REGION_A: begin
            vert = 1'b1;
         end
         ptds_pkg::REGION_B: begin
            vert = 1'b1;
            vsq  = sq_fix(dot5_ff[ptds_pkg::DOT_BP]);
         end
         ptds_pkg::REGION_C: begin
            vert = 1'b1;
            vsq  = sq_fix(dot5_ff[ptds_pkg::DOT_CP]);
         end
         ptds_pkg::REGION_AB: begin
            vv_in = dot5_ff[ptds_pkg::DOT_AP];
         end
         ptds_pkg::REGION_BC: begin
            vv_in = dot5_ff[ptds_pkg::DOT_BP];
            uu_in = dot5_ff[ptds_pkg::DOT_CB];
            dm_in = abs_dot(dbc);
         end
         ptds_pkg::REGION_CA: begin
            vv_in = dot5_ff[ptds_pkg::DOT_CP];
            uu_in = dot5_ff[ptds_pkg::DOT_AC];
            dm_in = abs_dot(dot5_ff[ptds_pkg::DOT_D6]);
         end
         default: begin
            vv_in = dot5_ff[ptds_pkg::DOT_AP];
         end
      endcase
      intr_in = (region5_ff == ptds_pkg::REGION_INT);
      den_in  = intr_in ? DNW'(nn_ff) : DNW'(uu_in);
      deg_in  = !vert && (den_in == '0);
      byp_in  = vert || deg_in;
      // A zero divisor falls back to the squared distance to vertex A.
      bval_in = vert ? vsq : sq_fix(dot5_ff[ptds_pkg::DOT_AP]);
   end

   always_ff @(posedge clock) begin
      if (rdy[5]) begin
         vv_ff      <= vv_in;
         uu_ff      <= uu_in;
         dm_ff      <= dm_in;
         sh_ff      <= sh_in;
         sl_ff      <= sl_in;
         den6_ff    <= den_in;
         deg6_ff    <= deg_in;
         byp6_ff    <= byp_in;
         intr6_ff   <= intr_in;
         bval6_ff   <= bval_in;
         region6_ff <= region5_ff;
      end
   end

   // Stage 7: numerator products, the square of AP.n taken in two halves.
   logic [2*DW-1:0]     vu_in, vu_ff, dd_in, dd_ff;
   logic [2*SHI-1:0]    hh_in, hh_ff;
   logic [SHI+SH-1:0]   hl_in, hl_ff;
   logic [2*SH-1:0]     ll_in, ll_ff;
   logic [DNW-1:0]      den7_ff;
   logic                deg7_ff, byp7_ff, intr7_ff;
   logic [DIST_W-1:0]   bval7_ff;
   ptds_pkg::region_type region7_ff;

   always_comb begin
      vu_in = (2*DW)'(vv_ff) * (2*DW)'(uu_ff);
      dd_in = (2*DW)'(dm_ff) * (2*DW)'(dm_ff);
      hh_in = (2*SHI)'(sh_ff) * (2*SHI)'(sh_ff);
      hl_in = (SHI+SH)'(sh_ff) * (SHI+SH)'(sl_ff);
      ll_in = (2*SH)'(sl_ff) * (2*SH)'(sl_ff);
   end

   always_ff @(posedge clock) begin
      if (rdy[6]) begin
         vu_ff      <= vu_in;
         dd_ff      <= dd_in;
         hh_ff      <= hh_in;
         hl_ff      <= hl_in;
         ll_ff      <= ll_in;
         den7_ff    <= den6_ff;
         deg7_ff    <= deg6_ff;
         byp7_ff    <= byp6_ff;
         intr7_ff   <= intr6_ff;
         bval7_ff   <= bval6_ff;
         region7_ff <= region6_ff;
      end
   end

   // Stage 8: assemble the numerator.
   logic [NMW-1:0]    num_in, num_ff;
   logic [DNW-1:0]    den8_ff;
   logic              deg8_ff, byp8_ff;
   logic [DIST_W-1:0] bval8_ff;
   ptds_pkg::region_type region8_ff;

   always_comb begin
      if (intr7_ff) begin
         num_in = (NMW'(hh_ff) << (2*SH)) + (NMW'(hl_ff) << (SH+1)) + NMW'(ll_ff);
      end else begin
         num_in = NMW'(vu_ff) - NMW'(dd_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[7]) begin
         num_ff     <= num_in;
         den8_ff    <= den7_ff;
         deg8_ff    <= deg7_ff;
         byp8_ff    <= byp7_ff;
         bval8_ff   <= bval7_ff;
         region8_ff <= region7_ff;
      end
   end

   // Division pipeline: entry 0 is the set-up stage, entry j+1 holds quotient bit j.
   logic [RW-1:0]     rem_in [DIST_W+1];
   logic [RW-1:0]     rem_ff [DIST_W+1];
   logic [DNW-1:0]    den_ff [DIST_W+1];
   logic [DIST_W-1:0] low_in [DIST_W+1];
   logic [DIST_W-1:0] low_ff [DIST_W+1];
   logic [DIST_W-1:0] quo_in [DIST_W+1];
   logic [DIST_W-1:0] quo_ff [DIST_W+1];
   logic              byp_in0;
   logic [DIST_W-1:0] bval_in0;
   logic              byp_ff [DIST_W+1];
   logic [DIST_W-1:0] bval_ff [DIST_W+1];
   logic              deg_ff [DIST_W+1];
   ptds_pkg::region_type region_ff [DIST_W+1];
   logic [NSW-1:0]    ns;
   logic [HW-1:0]     ns_hi;
   logic              ovf;

   // Set-up stage: a quotient of 2^50 or more saturates.
   always_comb begin
      ns        = NSW'(num_ff) << FRAC_BITS;
      ns_hi     = ns[NSW-1:DIST_W];
      ovf       = CW'(ns_hi) >= CW'(den8_ff);
      rem_in[0] = RW'(ns_hi);
      low_in[0] = ns[DIST_W-1:0];
      quo_in[0] = '0;
      byp_in0   = byp8_ff || ovf;
      bval_in0  = byp8_ff ? bval8_ff : '1;
   end

   always_ff @(posedge clock) begin
      if (rdy[DIV0]) begin
         rem_ff[0]    <= rem_in[0];
         low_ff[0]    <= low_in[0];
         quo_ff[0]    <= quo_in[0];
         den_ff[0]    <= den8_ff;
         byp_ff[0]    <= byp_in0;
         bval_ff[0]   <= bval_in0;
         deg_ff[0]    <= deg8_ff;
         region_ff[0] <= region8_ff;
      end
   end

   // Restoring division, one quotient bit per stage.
   for (genvar j = 0; j < DIST_W; j++) begin : g_div
      logic [RW-1:0] trial;
      logic          ge;

      always_comb begin
         trial       = {rem_ff[j][RW-2:0], low_ff[j][DIST_W-1]};
         ge          = trial >= RW'(den_ff[j]);
         rem_in[j+1] = ge ? (trial - RW'(den_ff[j])) : trial;
         low_in[j+1] = low_ff[j] << 1;
         quo_in[j+1] = {quo_ff[j][DIST_W-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (rdy[DIV0+1+j]) begin
            rem_ff[j+1]    <= rem_in[j+1];
            low_ff[j+1]    <= low_in[j+1];
            quo_ff[j+1]    <= quo_in[j+1];
            den_ff[j+1]    <= den_ff[j];
            byp_ff[j+1]    <= byp_ff[j];
            bval_ff[j+1]   <= bval_ff[j];
            deg_ff[j+1]    <= deg_ff[j];
            region_ff[j+1] <= region_ff[j];
         end
      end
   end

   // Response: vertex, fallback and saturated results bypass the quotient.
   logic [DIST_W-1:0] dist_sq;

   assign dist_sq   = byp_ff[DIST_W] ? bval_ff[DIST_W] : quo_ff[DIST_W];
   assign rsp_tdata = ptds_pkg::RSP_TDATA_W'({deg_ff[DIST_W], dist_sq, region_ff[DIST_W]});

endmodule

// ===== src/ptds_checker.sv =====
// Port-level checks of the point-to-triangle squared distance unit, bound to its top level.
module ptds_checker (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   input logic req_tready,
   input logic rsp_tvalid,
   input logic rsp_tready,
   input logic [ptds_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   localparam int DEG_BIT = ptds_pkg::REGION_W + ptds_pkg::DIST_W;

   logic [ptds_pkg::REGION_W-1:0] rsp_region;

   assign rsp_region = rsp_tdata[ptds_pkg::REGION_W-1:0];

   // A stalled response holds its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   // Reset empties the pipeline.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // With the output register empty every stage can move, so a request is taken.
   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request refused while output is empty");

   // Only edge and interior results have a divisor that can vanish.
   a_deg_region: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[DEG_BIT] |->
         (rsp_region == ptds_pkg::REGION_AB) || (rsp_region == ptds_pkg::REGION_BC) ||
         (rsp_region == ptds_pkg::REGION_CA) || (rsp_region == ptds_pkg::REGION_INT))
      else $error("degenerate flag on a vertex region");

   // Meant to flag a response without a request; its last term holds whenever the antecedent does, so it cannot fail.
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      !req_tvalid && !rsp_tvalid |=> !rsp_tvalid || $past(req_tvalid) || !$past(rsp_tvalid))
      else $error("response without request");

endmodule

bind point_triangle_distance_squared_unit ptds_checker u_ptds_checker (.*);
